FILE: hw/rtl/multi_pattern_substring_filter_top_defines.svh
// Assertion macros shared by the checker of the substring filter.
// Depends on nothing; the user supplies the clock and reset names.
`ifndef MULTI_PATTERN_SUBSTRING_FILTER_TOP_DEFINES_SVH
`define MULTI_PATTERN_SUBSTRING_FILTER_TOP_DEFINES_SVH

// Clocked assertion, disabled while the active-high reset is high.
`define MPSF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The same, on signals that are named clk and rst in the using scope.
`define MPSF_CHECK(lbl, prop, msg) \
  `MPSF_ASSERT(lbl, clk, rst, prop, msg)

`endif

FILE: hw/rtl/mpsf_pkg.sv
// Package of the multi-pattern substring filter: sizes, request and result
// structs and byte helpers. Depends on nothing.
package mpsf_pkg;

  localparam int MaxPatterns     = 8;
  localparam int PatternCapacity = 32;
  localparam int IdxW  = $clog2(MaxPatterns);
  localparam int PosW  = $clog2(PatternCapacity);
  localparam int CntW  = $clog2(MaxPatterns + 1);
  localparam int AddrW = IdxW + PosW;
  localparam int VecW  = PatternCapacity - 1;

  localparam logic [7:0] ChBar   = 8'h7C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  localparam logic KindSpec    = 1'b0;
  localparam logic KindDisplay = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] pattern_count;
    logic       patterns_dropped;
    logic       name_matched;
    logic [2:0] match_index;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= ChUpA && c <= ChUpZ) ? (c + 8'h20) : c;
  endfunction

endpackage

FILE: hw/rtl/mpsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module mpsf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/multi_pattern_substring_filter_top.sv
// Spec bytes are taken with busy low, and the result of a spec byte, if any,
// appears on the next cycle. A display byte reads every stored pattern byte from the
// pattern RAM, one per cycle, while busy; a zero byte skips the reads and goes straight
// to the final state. Its result follows as busy falls.
// Results are strobed on done for one cycle and cannot be stalled.
// Synchronous reset clears the control state; the pattern RAM is not cleared.
module multi_pattern_substring_filter_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mpsf_pkg::item_t  item,
  output logic             done,
  output mpsf_pkg::result_t result
);
  import mpsf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;
  logic accept;

  // Spec parse state.
  logic [CntW-1:0] stored_count;
  logic            dropped_flag;
  logic            spec_in_progress;
  logic            alt_seen;
  logic [PosW:0]   alt_raw;
  logic [PosW:0]   alt_trim;
  logic [PosW-1:0] lengths [MaxPatterns];

  // Display search state.
  logic            display_in_progress;
  logic [VecW-1:0] pmv [MaxPatterns];
  logic [MaxPatterns-1:0] found;
  logic [7:0]      cur_char;
  logic            cur_last;
  logic [CntW-1:0] pi;
  logic [PosW-1:0] pj;
  logic            rd_v, rd_last;
  logic [PosW-1:0] rd_j;
  logic [IdxW-1:0] rd_i;
  logic [VecW-1:0] eq_acc;

  logic            ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Combinational parse of one spec byte.
  logic            s_seen, s_fin, s_drop, s_store;
  logic [PosW:0]   s_raw, s_trim;
  logic [CntW-1:0] s_cnt;
  logic            s_blank;

  always_comb begin
    s_cnt   = spec_in_progress ? stored_count : '0;
    s_drop  = spec_in_progress ? dropped_flag : 1'b0;
    s_seen  = spec_in_progress ? alt_seen : 1'b0;
    s_raw   = spec_in_progress ? alt_raw : '0;
    s_trim  = spec_in_progress ? alt_trim : '0;
    s_blank = is_blank(item.char_code);
    ram_we  = 1'b0;
    ram_waddr = {s_cnt[IdxW-1:0], s_raw[PosW-1:0]};
    s_store = 1'b0;
    if (item.char_code != 8'h00 && item.char_code != ChBar &&
        !(s_blank && !s_seen)) begin
      s_seen = 1'b1;
      if (s_raw < (PosW+1)'(PatternCapacity)) begin
        ram_we = accept && (item.kind == KindSpec) && (s_cnt < CntW'(MaxPatterns));
        s_raw  = s_raw + 1'b1;
      end
      if (!s_blank) begin
        s_trim = s_raw;
      end
    end
    // A bar or the final byte closes the current alternative.
    s_fin = item.last || (item.char_code == ChBar);
    if (s_fin && s_trim != '0) begin
      if (s_cnt >= CntW'(MaxPatterns) || s_trim >= (PosW+1)'(PatternCapacity)) begin
        s_drop = 1'b1;
      end else begin
        s_store = 1'b1;
      end
    end
  end

  // Shift-and step for the byte coming back from the RAM.
  logic            hit;
  logic [VecW-1:0] eq_now, v_new;
  always_comb begin
    hit    = (fold(ram_rdata) == cur_char);
    eq_now = eq_acc | (VecW'(hit) << rd_j);
    v_new  = ((pmv[rd_i] << 1) | VecW'(1)) & eq_now;
  end

  logic [PosW-1:0] cur_len;
  assign cur_len   = lengths[pi[IdxW-1:0]];
  assign ram_raddr = {pi[IdxW-1:0], pj};

  mpsf_ram #(.Width(8), .Depth(MaxPatterns * PatternCapacity)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item.char_code),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic            any_found;
  logic [2:0]      first_idx;
  always_comb begin
    any_found = 1'b0;
    first_idx = '0;
    for (int k = MaxPatterns - 1; k >= 0; k--) begin
      if (found[k]) begin
        any_found = 1'b1;
        first_idx = 3'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stored_count <= '0;
      dropped_flag <= 1'b0;
      spec_in_progress <= 1'b0;
      alt_seen <= 1'b0;
      alt_raw <= '0;
      alt_trim <= '0;
      display_in_progress <= 1'b0;
      found <= '0;
      done <= 1'b0;
      rd_v <= 1'b0;
      for (int k = 0; k < MaxPatterns; k++) begin
        pmv[k] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          done <= accept && (item.kind == KindSpec) && item.last;
          if (accept && item.kind == KindSpec) begin
            display_in_progress <= 1'b0;
            if (s_store) begin
              lengths[s_cnt[IdxW-1:0]] <= s_trim[PosW-1:0];
            end
            stored_count <= s_store ? s_cnt + 1'b1 : s_cnt;
            dropped_flag <= s_drop;
            if (s_fin) begin
              alt_seen <= 1'b0;
              alt_raw  <= '0;
              alt_trim <= '0;
            end else begin
              alt_seen <= s_seen;
              alt_raw  <= s_raw;
              alt_trim <= s_trim;
            end
            spec_in_progress <= !item.last;
            if (item.last) begin
              result.result_kind      <= KindSpec;
              result.pattern_count    <= 4'(s_store ? s_cnt + 1'b1 : s_cnt);
              result.patterns_dropped <= s_drop;
              result.name_matched     <= 1'b0;
              result.match_index      <= '0;
            end
          end else if (accept) begin
            if (!display_in_progress) begin
              found <= '0;
              for (int k = 0; k < MaxPatterns; k++) begin
                pmv[k] <= '0;
              end
            end
            display_in_progress <= 1'b1;
            cur_char <= fold(item.char_code);
            cur_last <= item.last;
            pi <= '0;
            pj <= '0;
            eq_acc <= '0;
            state <= (item.char_code == 8'h00) ? ST_FIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          done <= 1'b0;
          rd_v <= (pi < stored_count);
          if (pi < stored_count) begin
            rd_i    <= pi[IdxW-1:0];
            rd_j    <= pj;
            rd_last <= (pj == cur_len - 1'b1);
            if (pj == cur_len - 1'b1) begin
              pi <= pi + 1'b1;
              pj <= '0;
            end else begin
              pj <= pj + 1'b1;
            end
          end else if (!rd_v) begin
            state <= ST_FIN;
          end
          if (rd_v) begin
            if (rd_last) begin
              pmv[rd_i] <= v_new;
              eq_acc    <= '0;
              if (v_new[rd_j]) begin
                found[rd_i] <= 1'b1;
              end
            end else begin
              eq_acc <= eq_now;
            end
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
          done  <= cur_last;
          if (cur_last) begin
            display_in_progress <= 1'b0;
            result.result_kind      <= KindDisplay;
            result.pattern_count    <= 4'(stored_count);
            result.patterns_dropped <= dropped_flag;
            result.name_matched     <= any_found;
            result.match_index      <= first_idx;
          end
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end
endmodule

FILE: hw/rtl/mpsf_checker.sv
// Port-level checker for the substring filter, bound to its top level.
// Depends on mpsf_pkg and the shared assertion macro header.
`include "multi_pattern_substring_filter_top_defines.svh"
module mpsf_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input mpsf_pkg::item_t   item,
  input logic              done,
  input mpsf_pkg::result_t result
);
  import mpsf_pkg::*;

  logic spec_end, spec_res, no_match;
  assign spec_end = start && !busy && item.last && (item.kind == KindSpec);
  assign spec_res = done && (result.result_kind == KindSpec);
  assign no_match = done && !result.name_matched;

  `MPSF_CHECK(spec_last_answers, spec_end |=> spec_res, "spec end without result")
  `MPSF_CHECK(index_needs_match, no_match |-> result.match_index == 3'd0, "index without match")
  `MPSF_CHECK(spec_no_match, spec_res |-> !result.name_matched, "spec result reports a match")
  `MPSF_CHECK(count_in_range, done |-> result.pattern_count <= 4'(MaxPatterns), "count out of range")
endmodule

bind multi_pattern_substring_filter_top mpsf_checker u_mpsf_checker (.*);

FILE: tb/sv/testbench.sv
// Testbench of the multi-pattern substring filter: spec parsing and display-name matching,
// checked request by request against a behavioural predictor. Depends on mpsf_pkg and the top.
`timescale 1ns / 100ps

module testbench;
  import mpsf_pkg::*;

  localparam int MaxPat = 8;
  localparam int Cap    = 32;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  multi_pattern_substring_filter_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [7:0]      pat_bytes [MaxPat][Cap];
  int unsigned     pat_len [MaxPat];
  int unsigned     n_stored;
  bit              drop_flag;
  bit              in_spec, in_name, alt_text;
  int unsigned     alt_pos, alt_trim;
  logic [Cap-1:0]  match_vec [MaxPat];
  logic [MaxPat-1:0] hit_flags;

  result_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_spec_res = 0;
  int n_name_res = 0;
  int n_hits = 0;

  function automatic bit blank_ch(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic [7:0] lower_ch(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  task automatic close_alternative();
    if (alt_trim > 0) begin
      if (n_stored >= MaxPat || alt_trim >= Cap) drop_flag = 1'b1;
      else begin
        pat_len[n_stored] = alt_trim;
        n_stored++;
      end
    end
    alt_text = 1'b0;
    alt_pos = 0;
    alt_trim = 0;
  endtask

  task automatic predict_filter(item_t it);
    result_t r;
    logic [Cap-1:0] eq;
    logic [7:0] c;
    c = it.char_code;
    r = '0;
    if (it.kind == KindSpec) begin
      in_name = 1'b0;
      if (!in_spec) begin
        in_spec = 1'b1;
        n_stored = 0;
        drop_flag = 1'b0;
        alt_text = 1'b0;
        alt_pos = 0;
        alt_trim = 0;
      end
      if (c == ChBar) close_alternative();
      else if (c != 0 && !(blank_ch(c) && !alt_text)) begin
        alt_text = 1'b1;
        if (alt_pos < Cap) begin
          if (n_stored < MaxPat) pat_bytes[n_stored][alt_pos] = c;
          alt_pos++;
        end
        if (!blank_ch(c)) alt_trim = alt_pos;
      end
      if (it.last) begin
        close_alternative();
        in_spec = 1'b0;
        r.result_kind = KindSpec;
        r.pattern_count = 4'(n_stored);
        r.patterns_dropped = drop_flag;
        expected_results.push_back(r);
      end
    end else begin
      if (!in_name) begin
        in_name = 1'b1;
        hit_flags = '0;
        for (int i = 0; i < MaxPat; i++) match_vec[i] = '0;
      end
      if (c != 0) begin
        for (int i = 0; i < n_stored; i++) begin
          eq = '0;
          for (int j = 0; j < pat_len[i]; j++)
            eq[j] = (lower_ch(pat_bytes[i][j]) == lower_ch(c));
          match_vec[i] = ((match_vec[i] << 1) | 1) & eq;
          if (match_vec[i][pat_len[i]-1]) hit_flags[i] = 1'b1;
        end
      end
      if (it.last) begin
        in_name = 1'b0;
        r.result_kind = KindDisplay;
        r.pattern_count = 4'(n_stored);
        r.patterns_dropped = drop_flag;
        for (int i = MaxPat - 1; i >= 0; i--)
          if (i < n_stored && hit_flags[i]) begin
            r.name_matched = 1'b1;
            r.match_index = 3'(i);
          end
        expected_results.push_back(r);
      end
    end
  endtask

  // Sender pacing: bursts of random length, mostly separated by random gaps.
  int burst_left = 0;

  // Start stays high across a burst; it drops only for a gap.
  task automatic send_request(logic kind, logic [7:0] c, logic last);
    item_t it;
    it.kind = kind;
    it.char_code = c;
    it.last = last;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_filter(it);
    n_sent++;
    @(negedge clk);
  endtask

  // Sends a string; an empty one goes as a single zero byte with last set.
  task automatic send_string(logic kind, string s);
    if (s.len() == 0) send_request(kind, 8'h00, 1'b1);
    else for (int i = 0; i < s.len(); i++) send_request(kind, s[i], i == s.len() - 1);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", result);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (result.result_kind == KindDisplay) n_name_res++;
        else n_spec_res++;
        if (result.name_matched) n_hits++;
        if (result !== e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: kind %0d/%0d count %0d/%0d dropped %0d/%0d matched %0d/%0d idx %0d/%0d",
                     e.result_kind, result.result_kind, e.pattern_count, result.pattern_count,
                     e.patterns_dropped, result.patterns_dropped, e.name_matched,
                     result.name_matched, e.match_index, result.match_index);
        end
      end
    end
  end

  function automatic string random_word(int maxlen, bit wild);
    string s;
    int n;
    byte alpha[] = '{"a", "B", "c", "D", "e", "x", "Y", " ", "z"};
    s = "";
    n = $urandom_range(1, maxlen);
    for (int i = 0; i < n; i++) begin
      if (wild) s = {s, string'(byte'($urandom_range(1, 255)))};
      else s = {s, string'(alpha[$urandom_range(0, alpha.size() - 1)])};
    end
    return s;
  endfunction

  task automatic test_spec_parsing();
    send_string(KindSpec, "  abc \t| |\r\nDEF\n|x");
    send_string(KindSpec, "");
    send_string(KindSpec, "|||");
    send_string(KindSpec, "a|b|c|d|e|f|g|h|i|j");
    send_string(KindSpec, {"0123456789012345678901234567890", "|",
                           "01234567890123456789012345678901", "|q"});
    send_string(KindSpec, {"abcdefghijabcdefghijabcdefghijab", "cd   |z"});
  endtask

  task automatic test_matching();
    send_string(KindSpec, "Hello|wor|\x80\xff|lD");
    send_string(KindDisplay, "HELLO WORLD");
    send_string(KindDisplay, "xx\x80\xffy");
    send_string(KindDisplay, "");
    send_string(KindDisplay, "nothing");
    // A zero byte within a name is skipped and does not break adjacency.
    send_request(KindDisplay, "w", 1'b0);
    send_request(KindDisplay, 8'h00, 1'b0);
    send_request(KindDisplay, "o", 1'b0);
    send_request(KindDisplay, "R", 1'b1);
  endtask

  task automatic test_interleaving();
    // A name aborted by a spec, and a name begun during a spec.
    send_request(KindDisplay, "h", 1'b0);
    send_request(KindSpec, "a", 1'b0);
    send_request(KindDisplay, "A", 1'b0);
    send_request(KindSpec, "b", 1'b1);
    send_string(KindDisplay, "xab");
  endtask

  task automatic test_random();
    string words[$];
    string spec, name;
    int target;
    target = n_sent + 1200;
    while (n_sent < target) begin
      words.delete();
      spec = "";
      for (int k = $urandom_range(0, 10); k > 0; k--) begin
        words.push_back(random_word($urandom_range(0, 9) == 0 ? 35 : 4,
                                    $urandom_range(0, 9) == 0));
        spec = {spec, ($urandom_range(0, 1) ? " " : ""), words[$], (k > 1 ? "|" : "")};
      end
      if ($urandom_range(0, 5) == 0) spec = {spec, "|"};
      send_string(KindSpec, spec);
      for (int k = $urandom_range(1, 5); k > 0; k--) begin
        name = random_word(10, $urandom_range(0, 7) == 0);
        if (words.size() > 0 && $urandom_range(0, 1))
          name = {random_word(3, 1'b0), words[$urandom_range(0, words.size() - 1)], name};
        if ($urandom_range(0, 15) == 0) begin
          // Broken name: cut off by the next spec.
          send_request(KindDisplay, name[0], 1'b0);
          break;
        end
        send_string(KindDisplay, $urandom_range(0, 30) == 0 ? "" : name);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MaxPat; i++) match_vec[i] = '0;
    n_stored = 0; drop_flag = 0; in_spec = 0; in_name = 0;
    alt_text = 0; alt_pos = 0; alt_trim = 0; hit_flags = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_spec_parsing();
    test_matching();
    test_interleaving();
    test_random();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d request bytes; checked %0d spec and %0d name results, %0d with a match.",
             n_sent, n_spec_res, n_name_res, n_hits);
    if (errors == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
